>>> rtl/arp_pkg.sv
// shared types, constants and microcode program of the aligned row partitioner
`timescale 1ns / 1ps
`default_nettype none
package arp_pkg;

  // field widths
  localparam int ROW_W   = 32;
  localparam int PART_W  = 7;
  localparam int ALIGN_W = 16;
  localparam int QUOT_W  = ROW_W + 1;
  localparam int TAIL_W  = PART_W + ALIGN_W;
  localparam int CNT_W   = 6;
  localparam int PC_W    = 4;

  // limits on the part count
  localparam logic [PART_W-1:0] MIN_PARTS = PART_W'(2);
  localparam logic [PART_W-1:0] MAX_PARTS = PART_W'(64);

  // one quotient bit per divider step
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QUOT_W);

  // request item
  typedef struct packed {
    logic [ROW_W-1:0]   total_rows;
    logic [PART_W-1:0]  part_count;
    logic [ALIGN_W-1:0] alignment;
  } req_t;

  // result item
  typedef struct packed {
    logic [ROW_W-1:0] part_start;
    logic [ROW_W-1:0] part_rows;
    logic             status;
    logic             last;
  } res_t;

  // status codes
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_BAD = 1'b1;

  // datapath operations of one microstep
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_CHECK,
    OP_DIV1,
    OP_DIV2,
    OP_EMIT,
    OP_LAST,
    OP_BAD
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_START,
    C_INVALID,
    C_LAST_PART,
    C_DIV_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // program addresses
  localparam logic [PC_W-1:0] A_IDLE  = PC_W'(0);
  localparam logic [PC_W-1:0] A_CHECK = PC_W'(1);
  localparam logic [PC_W-1:0] A_TOP   = PC_W'(2);
  localparam logic [PC_W-1:0] A_DIV1  = PC_W'(3);
  localparam logic [PC_W-1:0] A_WAIT1 = PC_W'(4);
  localparam logic [PC_W-1:0] A_DIV2  = PC_W'(5);
  localparam logic [PC_W-1:0] A_WAIT2 = PC_W'(6);
  localparam logic [PC_W-1:0] A_EMIT  = PC_W'(7);
  localparam logic [PC_W-1:0] A_LAST  = PC_W'(8);
  localparam logic [PC_W-1:0] A_BAD   = PC_W'(9);

  // microcode rom
  function automatic ctrl_t arp_ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: A_IDLE};
    case (pc)
      A_IDLE:  w = '{op: OP_LATCH, cond: C_NO_START,  target: A_IDLE};
      A_CHECK: w = '{op: OP_CHECK, cond: C_INVALID,   target: A_BAD};
      A_TOP:   w = '{op: OP_NOP,   cond: C_LAST_PART, target: A_LAST};
      A_DIV1:  w = '{op: OP_DIV1,  cond: C_NEXT,      target: A_IDLE};
      A_WAIT1: w = '{op: OP_NOP,   cond: C_DIV_BUSY,  target: A_WAIT1};
      A_DIV2:  w = '{op: OP_DIV2,  cond: C_NEXT,      target: A_IDLE};
      A_WAIT2: w = '{op: OP_NOP,   cond: C_DIV_BUSY,  target: A_WAIT2};
      A_EMIT:  w = '{op: OP_EMIT,  cond: C_ALWAYS,    target: A_TOP};
      A_LAST:  w = '{op: OP_LAST,  cond: C_ALWAYS,    target: A_IDLE};
      A_BAD:   w = '{op: OP_BAD,   cond: C_ALWAYS,    target: A_IDLE};
      default: w = '{op: OP_NOP,   cond: C_ALWAYS,    target: A_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/arp_div.sv
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module arp_div
  import arp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire logic [QUOT_W-1:0]  dividend,
  input  wire logic [ALIGN_W-1:0] divisor,
  output logic                    busy,
  output logic [QUOT_W-1:0]       quotient,
  output logic [ALIGN_W-1:0]      remainder
);

  logic [CNT_W-1:0]   cnt;
  logic [QUOT_W-1:0]  quot;
  logic [ALIGN_W-1:0] rem;
  logic [ALIGN_W-1:0] dvs;
  logic [ALIGN_W:0]   rem_sh;
  logic [ALIGN_W:0]   diff;
  logic               ge;
  logic [ALIGN_W-1:0] rem_next;

  // one trial subtraction
  always_comb begin
    rem_sh   = {rem, quot[QUOT_W-1]};
    diff     = rem_sh - {1'b0, dvs};
    ge       = (rem_sh >= {1'b0, dvs});
    rem_next = ge ? diff[ALIGN_W-1:0] : rem_sh[ALIGN_W-1:0];
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= DIV_STEPS;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // quotient and remainder shift
  always_ff @(posedge clk) begin
    if (load) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[QUOT_W-2:0], ge};
      rem  <= rem_next;
    end
  end

  assign quotient  = quot;
  assign remainder = rem;

endmodule
`default_nettype wire

>>> rtl/aligned_row_partitioner_core.sv
// microcoded aligned row partitioner, top level
//
// One request (total_rows, part_count, alignment) is taken when start is high
// and busy is low. The block then emits one result per part on res, each for a
// single cycle marked by done, with last set on the final one; the receiver
// cannot stall. An invalid request yields one result with status set. For a
// valid request, every part but the last runs two 33-step serial divisions
// (share of the remaining rows, then rounding to the alignment) in one shared
// divider, each with a load and a wait for the divider to finish, then emits
// its result and loops back; the last part takes the remaining rows without a
// division. The final result is on res in the cycle busy falls, and the next
// request can be taken in that cycle.
`timescale 1ns / 1ps
`default_nettype none
module aligned_row_partitioner_core
  import arp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  output logic      busy,
  output logic      done,
  output res_t      res
);

  logic [PC_W-1:0]    pc;
  logic [PC_W-1:0]    pc_next;
  ctrl_t              ctrl;
  logic               jump;

  logic [ROW_W-1:0]   rows;
  logic [PART_W-1:0]  parts;
  logic [ALIGN_W-1:0] align;
  logic [ROW_W-1:0]   start_row;
  logic [PART_W-1:0]  left;
  logic [TAIL_W-1:0]  tail;
  logic [ROW_W-1:0]   cap;
  logic [QUOT_W-1:0]  rounded;

  logic [ROW_W-1:0]   left_rows;
  logic [TAIL_W-1:0]  need;
  logic               invalid;
  logic [QUOT_W-1:0]  raw;
  logic [ROW_W-1:0]   count;

  logic               div_load;
  logic               div_busy;
  logic [QUOT_W-1:0]  div_dividend;
  logic [ALIGN_W-1:0] div_divisor;
  logic [QUOT_W-1:0]  div_q;
  logic [ALIGN_W-1:0] div_rem;

  // microcode fetch and sequencing
  always_comb begin
    ctrl = arp_ucode(pc);
    case (ctrl.cond)
      C_NEXT:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_START:  jump = !start;
      C_INVALID:   jump = invalid;
      C_LAST_PART: jump = (left == PART_W'(1));
      C_DIV_BUSY:  jump = div_busy;
      default:     jump = 1'b1;
    endcase
    pc_next = jump ? ctrl.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign busy = (pc != A_IDLE);

  // request checks and per-part arithmetic
  always_comb begin
    left_rows = rows - start_row;
    need      = TAIL_W'(parts) * TAIL_W'(align);
    invalid   = (rows == '0) || (parts < MIN_PARTS) || (parts > MAX_PARTS) ||
                (align == '0) || ({{(ROW_W-TAIL_W){1'b0}}, need} > rows);
    raw       = rounded - QUOT_W'(div_rem);
    count     = (raw < QUOT_W'(cap)) ? raw[ROW_W-1:0] : cap;
  end

  // divider operand select
  always_comb begin
    div_load     = (ctrl.op == OP_DIV1) || (ctrl.op == OP_DIV2);
    div_dividend = QUOT_W'(left_rows) + QUOT_W'(left) - QUOT_W'(1);
    div_divisor  = ALIGN_W'(left);
    if (ctrl.op == OP_DIV2) begin
      div_dividend = div_q + QUOT_W'(align) - QUOT_W'(1);
      div_divisor  = align;
    end
  end

  arp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .load      (div_load),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LATCH: begin
        rows  <= req.total_rows;
        parts <= req.part_count;
        align <= req.alignment;
      end
      OP_CHECK: begin
        start_row <= '0;
        left      <= parts;
      end
      OP_DIV1: begin
        tail <= TAIL_W'(left - PART_W'(1)) * TAIL_W'(align);
      end
      OP_DIV2: begin
        rounded <= div_dividend;
        cap     <= left_rows - ROW_W'(tail);
      end
      OP_EMIT: begin
        start_row <= start_row + count;
        left      <= left - PART_W'(1);
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_EMIT: res <= '{part_start: start_row, part_rows: count,
                        status: STAT_OK, last: 1'b0};
      OP_LAST: res <= '{part_start: start_row, part_rows: left_rows,
                        status: STAT_OK, last: 1'b1};
      OP_BAD:  res <= '{part_start: '0, part_rows: '0,
                        status: STAT_BAD, last: 1'b1};
      default: begin
      end
    endcase
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctrl.op == OP_EMIT) || (ctrl.op == OP_LAST) || (ctrl.op == OP_BAD);
    end
  end

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an item was taken");

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    done && res.status |-> res.last)
    else $error("invalid result not marked last");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    done && !res.last |-> busy)
    else $error("block went idle before the last result");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_load |-> !div_busy)
    else $error("divider loaded while still working");

  a_rows_cap: assert property (@(posedge clk) disable iff (rst)
    done && !res.status |-> res.part_rows != '0)
    else $error("valid part with no rows");

endmodule
`default_nettype wire
